// File: rtl/watm_pkg.sv
// ----------------------------------------------------------------------------
// watm_pkg
// Shared types and constants for the wildcard address table match core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package watm_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int NUM_LEVELS  = 5;

  localparam logic [15:0] WILD = 16'hFFFF;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] MODE_FULL  = 2'd0;
  localparam logic [1:0] MODE_EXACT = 2'd1;
  localparam logic [1:0] MODE_WILD  = 2'd2;

  localparam logic [2:0] LVL_EXACT = 3'd0;
  localparam logic [2:0] LVL_POINT = 3'd1;
  localparam logic [2:0] LVL_NODE  = 3'd2;
  localparam logic [2:0] LVL_NET   = 3'd3;
  localparam logic [2:0] LVL_ZONE  = 3'd4;
  localparam logic [2:0] LVL_NONE  = 3'd5;

  typedef struct packed {
    logic        operation;
    logic [5:0]  entry_index;
    logic [15:0] zone;
    logic [15:0] net;
    logic [15:0] node_number;
    logic [15:0] point;
    logic [1:0]  match_mode;
  } in_item_t;

  typedef struct packed {
    logic [6:0] match_index;
    logic       hit;
    logic [2:0] match_level;
  } out_item_t;

endpackage

// File: rtl/wildcard_address_table_match_core.sv
// ----------------------------------------------------------------------------
// wildcard_address_table_match_core
// Address table with exact and hierarchical wildcard lookup over one RAM scan.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  input     start, busy, in_item             start in, busy out
//  result    out_valid, out_item              out, one-cycle strobe
//  config    cfg_we, cfg_wdata                in, entry count register
//
//  write item: stored in the accept cycle, result strobe on the next cycle,
//    busy stays low.
//  lookup item: one RAM read per entry, all five levels judged per read;
//    the scan reads entries 0 to count - 1 (count = entry count, capped
//    at the table depth; no reads when the count is zero) through the
//    single RAM read port, then registers the result strobe.
//  reset clears control only; table contents are undefined until written.
//  results cannot be held off; busy is high during a lookup scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wildcard_address_table_match_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  watm_pkg::in_item_t  in_item,
  output logic                out_valid,
  output watm_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata
);
  import watm_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic [63:0]       table_mem [TABLE_DEPTH];
  logic [63:0]       rd_data_r;

  logic              state_r, state_nxt;
  logic [6:0]        cfg_count_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  scan_idx_r;
  logic              rd_pend_r;
  logic [ADDR_W-1:0] rd_idx_r;
  logic [15:0]       key_zone_r, key_net_r, key_node_r, key_point_r;
  logic [1:0]        mode_r;
  logic [NUM_LEVELS-1:0] found_r;
  logic [ADDR_W-1:0] found_idx_r [NUM_LEVELS];

  logic              out_valid_r;
  out_item_t         out_item_r;

  logic              accept;
  logic              issue;
  logic              scan_done;
  logic [CNT_W-1:0]  eff_count;
  logic [15:0]       ez, en, ed, ep;
  logic [NUM_LEVELS-1:0] lvl_hit;
  logic [NUM_LEVELS-1:0] lvl_en;
  logic              sel_hit;
  logic [2:0]        sel_lvl;
  logic [ADDR_W-1:0] sel_idx;

  assign busy      = (state_r == ST_SCAN);
  assign accept    = start & ~busy;
  assign issue     = (state_r == ST_SCAN) && (scan_idx_r < count_r);
  assign scan_done = (state_r == ST_SCAN) && !issue && !rd_pend_r;

  // entry count above the table depth is capped
  assign eff_count = (cfg_count_r > 7'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                     : CNT_W'(cfg_count_r);

  // table ram: write port in idle, read port during the scan
  always_ff @(posedge clk) begin
    if (accept && in_item.operation == OP_WRITE) begin
      table_mem[in_item.entry_index] <= {in_item.zone, in_item.net,
                                         in_item.node_number, in_item.point};
    end
    rd_data_r <= table_mem[scan_idx_r[ADDR_W-1:0]];
  end

  assign ez = rd_data_r[63:48];
  assign en = rd_data_r[47:32];
  assign ed = rd_data_r[31:16];
  assign ep = rd_data_r[15:0];

  always_comb begin
    lvl_hit[LVL_EXACT] = (ez == key_zone_r) && (en == key_net_r) &&
                         (ed == key_node_r) && (ep == key_point_r);
    lvl_hit[LVL_POINT] = (ep == WILD) && (ez == key_zone_r) &&
                         (en == key_net_r) && (ed == key_node_r);
    lvl_hit[LVL_NODE]  = (ed == WILD) && (ez == key_zone_r) && (en == key_net_r);
    lvl_hit[LVL_NET]   = (en == WILD) && (ez == key_zone_r);
    lvl_hit[LVL_ZONE]  = (ez == WILD);
  end

  // mode three falls back to exact only
  always_comb begin
    lvl_en            = '0;
    lvl_en[LVL_EXACT] = (mode_r != MODE_WILD);
    if (mode_r == MODE_FULL || mode_r == MODE_WILD) begin
      lvl_en[LVL_POINT] = 1'b1;
      lvl_en[LVL_NODE]  = 1'b1;
      lvl_en[LVL_NET]   = 1'b1;
      lvl_en[LVL_ZONE]  = 1'b1;
    end
  end

  // lowest enabled level with a hit wins
  always_comb begin
    sel_hit = 1'b0;
    sel_lvl = LVL_NONE;
    sel_idx = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (lvl_en[l] && found_r[l]) begin
        sel_hit = 1'b1;
        sel_lvl = 3'(l);
        sel_idx = found_idx_r[l];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_item.operation == OP_LOOKUP) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_count_r <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= '0;
      scan_idx_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= issue;
      out_valid_r <= (accept && in_item.operation == OP_WRITE) || scan_done;
      if (cfg_we) begin
        cfg_count_r <= cfg_wdata;
      end
      if (accept) begin
        found_r    <= '0;
        scan_idx_r <= '0;
      end else begin
        if (issue) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
        if (rd_pend_r) begin
          found_r <= found_r | lvl_hit;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      key_zone_r  <= in_item.zone;
      key_net_r   <= in_item.net;
      key_node_r  <= in_item.node_number;
      key_point_r <= in_item.point;
      mode_r      <= in_item.match_mode;
      count_r     <= eff_count;
    end
    if (issue) begin
      rd_idx_r <= scan_idx_r[ADDR_W-1:0];
    end
    if (rd_pend_r) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (lvl_hit[l] && !found_r[l]) begin
          found_idx_r[l] <= rd_idx_r;
        end
      end
    end
    if (accept && in_item.operation == OP_WRITE) begin
      out_item_r.match_index <= '0;
      out_item_r.hit         <= 1'b0;
      out_item_r.match_level <= LVL_NONE;
    end else if (scan_done) begin
      out_item_r.match_index <= sel_hit ? 7'(sel_idx) : 7'(count_r);
      out_item_r.hit         <= sel_hit;
      out_item_r.match_level <= sel_lvl;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // a hit always carries a real level, a miss never does
  a_hit_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.hit == (out_item.match_level != LVL_NONE)))
    else $error("hit flag and match level disagree");

  // a write transfer is answered on the next cycle
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.operation == OP_WRITE) |=> out_valid)
    else $error("write transfer without result");

  // reads are only in flight during the scan
  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == ST_SCAN))
    else $error("table read outside the scan");

  // a hit index lies inside the scanned range
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.hit) |-> (CNT_W'(out_item.match_index) < count_r))
    else $error("hit index beyond entry count");

endmodule

// File: sim/wildcard_address_table_match_core_tb.sv
// ----------------------------------------------------------------------------
// wildcard_address_table_match_core_tb
// Self-checking bench for the address table: writes entries, changes the
// entry count between phases and fires lookups in every match mode. Each
// transfer is predicted in a scoreboard and each result strobe is checked
// against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wildcard_address_table_match_core_tb;
  import watm_pkg::*;

  localparam int          IDLE_LIMIT       = 1000;
  localparam int          RANDOM_ITEMS     = 1300;
  localparam int          TAIL_CYCLES      = 80;
  localparam logic [1:0]  MODE_EXACT_ALIAS = 2'd3;

  typedef struct packed {
    logic [15:0] zone;
    logic [15:0] net;
    logic [15:0] node_number;
    logic [15:0] point;
  } entry_t;

  class match_scoreboard;
    entry_t     addr_table[TABLE_DEPTH];
    logic [6:0] entry_count;
    out_item_t  expected_results[$];
    int         error_count;

    function new();
      entry_count = '0;
      error_count = 0;
      foreach (addr_table[i]) addr_table[i] = '0;
    endfunction

    function bit level_hit(entry_t e, logic [2:0] lvl, in_item_t a);
      case (lvl)
        LVL_EXACT: return e.zone == a.zone && e.net == a.net &&
                          e.node_number == a.node_number && e.point == a.point;
        LVL_POINT: return e.point == WILD && e.zone == a.zone && e.net == a.net &&
                          e.node_number == a.node_number;
        LVL_NODE:  return e.node_number == WILD && e.zone == a.zone && e.net == a.net;
        LVL_NET:   return e.net == WILD && e.zone == a.zone;
        default:   return e.zone == WILD;
      endcase
    endfunction

    function out_item_t best_match(in_item_t a);
      out_item_t  r;
      logic [6:0] lim;
      logic [2:0] first_lvl;
      logic [2:0] last_lvl;
      logic [2:0] lv;
      r.match_index = '0;
      r.hit         = 1'b0;
      r.match_level = LVL_NONE;
      if (a.operation == OP_WRITE) return r;
      lim       = (entry_count > TABLE_DEPTH) ? 7'(TABLE_DEPTH) : entry_count;
      first_lvl = (a.match_mode == MODE_WILD) ? LVL_POINT : LVL_EXACT;
      last_lvl  = (a.match_mode == MODE_FULL || a.match_mode == MODE_WILD) ? LVL_ZONE
                                                                            : LVL_EXACT;
      for (lv = first_lvl; lv <= last_lvl; lv++) begin
        for (int i = 0; i < int'(lim); i++) begin
          if (level_hit(addr_table[i], lv, a)) begin
            r.match_index = 7'(i);
            r.hit         = 1'b1;
            r.match_level = lv;
            return r;
          end
        end
      end
      r.match_index = lim;
      return r;
    endfunction

    function void note_item(in_item_t a);
      expected_results.push_back(best_match(a));
      if (a.operation == OP_WRITE)
        addr_table[a.entry_index] = {a.zone, a.net, a.node_number, a.point};
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        error_count++;
        return;
      end
      want = expected_results.pop_front();
      if (got.match_index !== want.match_index) begin
        $display("%0t: match_index expected %0d actual %0d", $time,
                 want.match_index, got.match_index);
        error_count++;
      end
      if (got.hit !== want.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
        error_count++;
      end
      if (got.match_level !== want.match_level) begin
        $display("%0t: match_level expected %0d actual %0d", $time,
                 want.match_level, got.match_level);
        error_count++;
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  logic       busy;
  in_item_t   in_item   = '0;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_we    = 1'b0;
  logic [6:0] cfg_wdata = '0;

  match_scoreboard sb = new();
  bit              slot_written[TABLE_DEPTH];
  bit              gapless;
  int              idle_cycles = 0;

  wildcard_address_table_match_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  // counts cycles with neither an input transfer nor a result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic int draw_gap();
    return gapless ? 0 : int'($urandom_range(0, 14));
  endfunction

  function automatic logic [15:0] pick_field();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom_range(0, 3));
    if (r < 8) return WILD;
    return 16'($urandom());
  endfunction

  function automatic int effective_count();
    return (sb.entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(sb.entry_count);
  endfunction

  function automatic in_item_t make_item(logic op, logic [5:0] slot, logic [15:0] z,
                                         logic [15:0] n, logic [15:0] d, logic [15:0] p,
                                         logic [1:0] mode);
    in_item_t it;
    it.operation   = op;
    it.entry_index = slot;
    it.zone        = z;
    it.net         = n;
    it.node_number = d;
    it.point       = p;
    it.match_mode  = mode;
    return it;
  endfunction

  // entered just after a rising edge (or at the start); returns at the transfer edge
  task automatic send_item(in_item_t it, int gap);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    if (it.operation == OP_WRITE) slot_written[it.entry_index] = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_item(it);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_slot(logic [5:0] slot);
    send_item(make_item(OP_WRITE, slot, pick_field(), pick_field(), pick_field(),
                        pick_field(), 2'($urandom_range(0, 3))), draw_gap());
  endtask

  task automatic set_entry_count(logic [6:0] value);
    int eff;
    eff = (value > TABLE_DEPTH) ? TABLE_DEPTH : int'(value);
    // every slot the search will read must hold a written entry
    for (int i = 0; i < eff; i++)
      if (!slot_written[i]) write_slot(6'(i));
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.entry_count = value;
  endtask

  task automatic random_item();
    in_item_t it;
    entry_t   e;
    int       eff;
    int       slot;
    eff = effective_count();
    if ($urandom_range(0, 9) < 3) begin
      if (eff > 0 && $urandom_range(0, 2) != 0) slot = $urandom_range(0, eff - 1);
      else slot = $urandom_range(0, TABLE_DEPTH - 1);
      write_slot(6'(slot));
    end else begin
      if (eff > 0 && $urandom_range(0, 9) < 6) begin
        // start from a stored entry so the wildcard levels get hit
        e = sb.addr_table[$urandom_range(0, eff - 1)];
        if (e.zone == WILD)        e.zone        = pick_field();
        if (e.net == WILD)         e.net         = pick_field();
        if (e.node_number == WILD) e.node_number = pick_field();
        if (e.point == WILD)       e.point       = pick_field();
        if ($urandom_range(0, 1) == 1) begin
          case ($urandom_range(0, 3))
            0:       e.zone        = pick_field();
            1:       e.net         = pick_field();
            2:       e.node_number = pick_field();
            default: e.point       = pick_field();
          endcase
        end
      end else begin
        e = {pick_field(), pick_field(), pick_field(), pick_field()};
      end
      it = make_item(OP_LOOKUP, 6'($urandom_range(0, TABLE_DEPTH - 1)), e.zone, e.net,
                     e.node_number, e.point, 2'($urandom_range(0, 3)));
      send_item(it, draw_gap());
    end
  endtask

  task automatic lookup(logic [15:0] z, logic [15:0] n, logic [15:0] d, logic [15:0] p,
                        logic [1:0] mode);
    send_item(make_item(OP_LOOKUP, 6'($urandom_range(0, 63)), z, n, d, p, mode),
              draw_gap());
  endtask

  task automatic store(logic [5:0] slot, logic [15:0] z, logic [15:0] n, logic [15:0] d,
                       logic [15:0] p);
    send_item(make_item(OP_WRITE, slot, z, n, d, p, MODE_FULL), draw_gap());
  endtask

  initial begin
    int remaining;
    int phase;
    int n_items;
    int c;
    foreach (slot_written[i]) slot_written[i] = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, one entry per level, extremes of the fields
    gapless = 1'b0;
    lookup(16'd2, 16'd10, 16'd20, 16'd30, MODE_FULL);
    store(6'd0, 16'd2, 16'd10, 16'd20, 16'd30);
    store(6'd1, 16'd2, 16'd10, 16'd20, WILD);
    store(6'd2, 16'd2, 16'd10, WILD, WILD);
    store(6'd3, 16'd2, WILD, WILD, WILD);
    store(6'd4, WILD, WILD, WILD, WILD);
    store(6'd5, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(make_item(OP_WRITE, 6'd63, WILD, WILD, WILD, WILD, MODE_EXACT_ALIAS), 0);
    set_entry_count(7'd6);
    lookup(16'd2, 16'd10, 16'd20, 16'd30, MODE_FULL);
    lookup(16'd2, 16'd10, 16'd20, 16'd31, MODE_FULL);
    lookup(16'd2, 16'd10, 16'd21, 16'd30, MODE_FULL);
    lookup(16'd2, 16'd11, 16'd20, 16'd30, MODE_FULL);
    lookup(16'd3, 16'd10, 16'd20, 16'd30, MODE_FULL);
    lookup(16'd2, 16'd10, 16'd20, 16'd30, MODE_EXACT);
    lookup(16'd2, 16'd10, 16'd20, 16'd31, MODE_EXACT);
    lookup(16'd2, 16'd10, 16'd20, 16'd30, MODE_WILD);
    lookup(16'd2, 16'd10, 16'd20, 16'd31, MODE_EXACT_ALIAS);
    lookup(16'd2, 16'd10, 16'd20, 16'd30, MODE_EXACT_ALIAS);
    // all-ones address is compared as a plain value
    lookup(WILD, WILD, WILD, WILD, MODE_EXACT);
    lookup(16'd0, 16'd0, 16'd0, 16'd0, MODE_EXACT);
    lookup(16'd7, 16'd7, 16'd7, 16'd7, MODE_WILD);
    set_entry_count(7'd4);
    lookup(16'd9, 16'd9, 16'd9, 16'd9, MODE_FULL);

    // random phases, each with its own entry count
    remaining = RANDOM_ITEMS;
    phase     = 0;
    while (remaining > 0) begin
      case (phase)
        0: c = 0;
        1: c = 1;
        2: c = TABLE_DEPTH;
        3: c = 127;
        4: c = TABLE_DEPTH + 1;
        default: begin
          case ($urandom_range(0, 19))
            0, 1, 2: c = $urandom_range(13, TABLE_DEPTH);
            3, 4, 5: c = $urandom_range(0, 127);
            default: c = $urandom_range(1, 12);
          endcase
        end
      endcase
      set_entry_count(7'(c));
      gapless = ($urandom_range(0, 2) == 0);
      n_items = $urandom_range(60, 140);
      repeat (n_items) begin
        random_item();
        remaining--;
        if ($urandom_range(0, 59) == 0) drain_results();
      end
      phase++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.expected_results.size() != 0) begin
      $display("%0t: results missing, expected %0d more actual 0", $time,
               sb.expected_results.size());
      sb.error_count++;
    end
    if (sb.error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/watm_pkg.sv
rtl/wildcard_address_table_match_core.sv
sim/wildcard_address_table_match_core_tb.sv
